/* src/lfp_pkg.sv */
// lfp_pkg: shared constants for the length prefixed frame parser
// record kinds, error codes, register indexes and register reset values
// no dependencies
package lfp_pkg;

   localparam int BYTE_W      = 8;
   localparam int KIND_W      = 2;
   localparam int FTYPE_W     = 2;
   localparam int ID_W        = 64;
   localparam int LEN_W       = 32;
   localparam int ERR_W       = 3;
   localparam int MAGIC_W     = 16;
   localparam int VER_W       = 8;
   localparam int HCOUNT_W    = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   typedef logic [KIND_W-1:0] kind_type;
   typedef logic [ERR_W-1:0] err_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam kind_type KIND_HEADER = 2'd0;
   localparam kind_type KIND_BODY   = 2'd1;
   localparam kind_type KIND_ERROR  = 2'd2;

   localparam err_type ERR_NONE    = 3'd0;
   localparam err_type ERR_MAGIC   = 3'd1;
   localparam err_type ERR_VERSION = 3'd2;
   localparam err_type ERR_LENGTH  = 3'd3;
   localparam err_type ERR_TYPE    = 3'd4;

   localparam csr_index_type CSR_MAGIC   = 2'd0;
   localparam csr_index_type CSR_VERSION = 2'd1;
   localparam csr_index_type CSR_MAX_LEN = 2'd2;

   localparam logic [MAGIC_W-1:0] MAGIC_RESET   = 16'h0000;
   localparam logic [VER_W-1:0]   VERSION_RESET = 8'd1;
   localparam logic [LEN_W-1:0]   MAX_LEN_RESET = 32'd65536;

   // header byte positions
   localparam logic [HCOUNT_W-1:0] HDR_WORD_END = 4'd8;
   localparam logic [HCOUNT_W-1:0] HDR_LAST     = 4'd15;

   localparam logic [BYTE_W-1:0] FTYPE_MIN = 8'd1;
   localparam logic [BYTE_W-1:0] FTYPE_MAX = 8'd3;

endpackage

/* src/length_prefixed_frame_parser_top.sv */
// length_prefixed_frame_parser_top: byte stream deframer with a 16-byte header
// depends on lfp_pkg
//
//   channel  ports      direction  per item
//   req      req_*      in         one stream byte
//   rsp      rsp_*      out        header record, body byte or error record
//   csr      csr_*      in         register write, no wait
//
// one byte is accepted per clock while ready; each byte updates the parse state
// and, where it yields a record, loads the result register in the same cycle
// reset clears the parse state and registers to their defaults, hunting a header
// req_ready drops only while a held record is not taken on rsp
module length_prefixed_frame_parser_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lfp_pkg::BYTE_W-1:0]          req_byte_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lfp_pkg::KIND_W-1:0]          rsp_record_kind,
   output logic [lfp_pkg::FTYPE_W-1:0]         rsp_frame_type,
   output logic [lfp_pkg::ID_W-1:0]            rsp_frame_id,
   output logic [lfp_pkg::LEN_W-1:0]           rsp_body_length,
   output logic [lfp_pkg::BYTE_W-1:0]          rsp_data_byte,
   output logic [lfp_pkg::ERR_W-1:0]           rsp_error_code,
   output logic                                rsp_last,
   input  logic                                csr_we,
   input  logic [lfp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lfp_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import lfp_pkg::*;

   logic [MAGIC_W-1:0]  magic_ff;
   logic [VER_W-1:0]    version_ff;
   logic [LEN_W-1:0]    max_len_ff;

   logic [HCOUNT_W-1:0] header_count_ff, header_count_in;
   logic [ID_W-1:0]     header_word_ff, header_word_in;
   logic [ID_W-9:0]     id_word_ff, id_word_in;
   logic                in_body_ff, in_body_in;
   logic [LEN_W-1:0]    body_remaining_ff, body_remaining_in;

   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            kind_ff, kind_in;
   logic [FTYPE_W-1:0]  ftype_ff, ftype_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [BYTE_W-1:0]   data_ff, data_in;
   err_type             err_ff, err_in;
   logic                last_ff, last_in;

   logic                accept;
   logic                emit;
   logic [LEN_W-1:0]    remaining_dec;
   logic [MAGIC_W-1:0]  hdr_magic;
   logic [VER_W-1:0]    hdr_version;
   logic [BYTE_W-1:0]   hdr_ftype;
   logic [LEN_W-1:0]    hdr_len;
   err_type             hdr_err;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign remaining_dec = body_remaining_ff - LEN_W'(1);
   assign hdr_magic     = header_word_ff[ID_W-1 -: MAGIC_W];
   assign hdr_version   = header_word_ff[ID_W-MAGIC_W-1 -: VER_W];
   assign hdr_ftype     = header_word_ff[LEN_W+BYTE_W-1 -: BYTE_W];
   assign hdr_len       = header_word_ff[LEN_W-1:0];

   // first failing check wins
   always_comb begin
      priority if (hdr_magic != magic_ff) begin
         hdr_err = ERR_MAGIC;
      end else if (hdr_version != version_ff) begin
         hdr_err = ERR_VERSION;
      end else if (hdr_len > max_len_ff) begin
         hdr_err = ERR_LENGTH;
      end else if (hdr_ftype < FTYPE_MIN || hdr_ftype > FTYPE_MAX) begin
         hdr_err = ERR_TYPE;
      end else begin
         hdr_err = ERR_NONE;
      end
   end

   always_comb begin
      header_count_in   = header_count_ff;
      header_word_in    = header_word_ff;
      id_word_in        = id_word_ff;
      in_body_in        = in_body_ff;
      body_remaining_in = body_remaining_ff;
      emit     = 1'b0;
      kind_in  = KIND_BODY;
      ftype_in = '0;
      id_in    = '0;
      len_in   = '0;
      data_in  = '0;
      err_in   = ERR_NONE;
      last_in  = 1'b0;
      if (accept) begin
         priority if (in_body_ff) begin
            emit              = 1'b1;
            body_remaining_in = remaining_dec;
            data_in           = req_byte_in;
            last_in           = (remaining_dec == '0);
            if (remaining_dec == '0) begin
               in_body_in      = 1'b0;
               header_count_in = '0;
            end
         end else if (header_count_ff < HDR_WORD_END) begin
            header_word_in  = {header_word_ff[ID_W-BYTE_W-1:0], req_byte_in};
            header_count_in = header_count_ff + HCOUNT_W'(1);
         end else if (header_count_ff < HDR_LAST) begin
            id_word_in      = {id_word_ff[ID_W-2*BYTE_W-1:0], req_byte_in};
            header_count_in = header_count_ff + HCOUNT_W'(1);
         end else begin
            // header complete
            emit            = 1'b1;
            header_count_in = '0;
            if (hdr_err != ERR_NONE) begin
               kind_in = KIND_ERROR;
               err_in  = hdr_err;
            end else begin
               kind_in  = KIND_HEADER;
               ftype_in = hdr_ftype[FTYPE_W-1:0];
               id_in    = {id_word_ff, req_byte_in};
               len_in   = hdr_len;
               last_in  = (hdr_len == '0);
               if (hdr_len != '0) begin
                  in_body_in        = 1'b1;
                  body_remaining_in = hdr_len;
               end
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff          <= MAGIC_RESET;
         version_ff        <= VERSION_RESET;
         max_len_ff        <= MAX_LEN_RESET;
         header_count_ff   <= '0;
         header_word_ff    <= '0;
         id_word_ff        <= '0;
         in_body_ff        <= 1'b0;
         body_remaining_ff <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         header_count_ff   <= header_count_in;
         header_word_ff    <= header_word_in;
         id_word_ff        <= id_word_in;
         in_body_ff        <= in_body_in;
         body_remaining_ff <= body_remaining_in;
         rsp_valid_ff      <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_MAGIC:   magic_ff   <= csr_wdata[MAGIC_W-1:0];
               CSR_VERSION: version_ff <= csr_wdata[VER_W-1:0];
               CSR_MAX_LEN: max_len_ff <= csr_wdata[LEN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff  <= kind_in;
         ftype_ff <= ftype_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         data_ff  <= data_in;
         err_ff   <= err_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_record_kind = kind_ff;
   assign rsp_frame_type  = ftype_ff;
   assign rsp_frame_id    = id_ff;
   assign rsp_body_length = len_ff;
   assign rsp_data_byte   = data_ff;
   assign rsp_error_code  = err_ff;
   assign rsp_last        = last_ff;

   a_body_count_zero: assert property (@(posedge clock) disable iff (reset)
      in_body_ff |-> header_count_ff == '0)
      else $error("header count not zero during body");

   a_body_remaining: assert property (@(posedge clock) disable iff (reset)
      in_body_ff |-> body_remaining_ff != '0)
      else $error("body active with nothing remaining");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("item accepted while held record not taken");

   a_error_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff == KIND_ERROR) |-> (!last_ff && err_ff != ERR_NONE))
      else $error("malformed error record");

endmodule

/* verif/length_prefixed_frame_parser_top_tb.sv */
// length_prefixed_frame_parser_top_tb: self-checking bench for the frame parser
// a directed frame table, then random frames, noise and truncated headers, checked
// against an in-bench deframer model; depends on lfp_pkg and the parser top level
module length_prefixed_frame_parser_top_tb;
   import lfp_pkg::*;

   localparam int unsigned HDR_BYTES      = 16;
   localparam int unsigned MAX_GAP        = 18;
   localparam int unsigned LONG_HOLD      = 80;
   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned END_CYCLES     = 8;
   localparam int unsigned NUM_PHASES     = 12;
   localparam int unsigned PHASE_BYTES    = 120;
   localparam int unsigned STALL_PHASE    = 3;
   localparam int unsigned NOISY_MAX_LEN  = 48;
   localparam int unsigned BODY_CAP       = 24;
   localparam int unsigned N_DIRECTED     = 14;
   localparam csr_index_type CSR_SPARE    = 2'd3;

   typedef struct packed {
      kind_type              kind;
      logic [FTYPE_W-1:0]    ftype;
      logic [ID_W-1:0]       id;
      logic [LEN_W-1:0]      len;
      logic [BYTE_W-1:0]     data;
      err_type               err;
      logic                  last;
   } frame_record_type;

   typedef struct packed {
      logic                  load_cfg;
      logic [MAGIC_W-1:0]    cfg_magic;
      logic [VER_W-1:0]      cfg_version;
      logic [LEN_W-1:0]      cfg_max_len;
      logic [MAGIC_W-1:0]    magic;
      logic [VER_W-1:0]      version;
      logic [BYTE_W-1:0]     ftype;
      logic [LEN_W-1:0]      len;
      logic [ID_W-1:0]       id;
      logic                  typed;
      err_type               err;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [BYTE_W-1:0] req_byte_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [KIND_W-1:0] rsp_record_kind;
   logic [FTYPE_W-1:0] rsp_frame_type;
   logic [ID_W-1:0] rsp_frame_id;
   logic [LEN_W-1:0] rsp_body_length;
   logic [BYTE_W-1:0] rsp_data_byte;
   logic [ERR_W-1:0] rsp_error_code;
   logic rsp_last;
   logic csr_we = 1'b0;
   csr_index_type csr_index = CSR_MAGIC;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // deframer model state and its copy of the registers
   logic [HCOUNT_W-1:0] hdr_count;
   logic [ID_W-1:0] hdr_word;
   logic [ID_W-1:0] id_word;
   logic in_body;
   logic [LEN_W-1:0] body_left;
   logic [MAGIC_W-1:0] cfg_magic;
   logic [VER_W-1:0] cfg_version;
   logic [LEN_W-1:0] cfg_max_len;

   frame_record_type expected_records[$];
   int unsigned mismatches = 0;
   int unsigned bytes_offered = 0;
   int unsigned stall_cycles = 0;
   bit req_gaps = 1'b0;
   bit rsp_gaps = 1'b0;
   bit rsp_hold_request = 1'b0;

   directed_row_type directed_rows [N_DIRECTED] = '{
      '{1'b1, MAGIC_RESET, VERSION_RESET, MAX_LEN_RESET,
        16'h0000, 8'h01, 8'h01, 32'd0, 64'h0, 1'b0, ERR_NONE},
      '{1'b0, 16'h0, 8'h0, 32'h0,
        16'hFFFF, 8'h01, 8'h01, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ERR_MAGIC},
      '{1'b0, 16'h0, 8'h0, 32'h0,
        16'h0000, 8'h00, 8'h01, 32'd0, 64'h0, 1'b1, ERR_VERSION},
      '{1'b0, 16'h0, 8'h0, 32'h0,
        16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 64'h0, 1'b1, ERR_MAGIC},
      '{1'b0, 16'h0, 8'h0, 32'h0,
        16'h0000, 8'hFF, 8'h00, 32'hFFFF_FFFF, 64'h0, 1'b1, ERR_VERSION},
      '{1'b0, 16'h0, 8'h0, 32'h0,
        16'h0000, 8'h01, 8'h00, 32'd65537, 64'h0, 1'b1, ERR_LENGTH},
      '{1'b0, 16'h0, 8'h0, 32'h0,
        16'h0000, 8'h01, 8'h00, 32'd0, 64'h0, 1'b1, ERR_TYPE},
      '{1'b0, 16'h0, 8'h0, 32'h0,
        16'h0000, 8'h01, 8'h04, 32'd0, 64'h0, 1'b1, ERR_TYPE},
      '{1'b0, 16'h0, 8'h0, 32'h0,
        16'h0000, 8'h01, 8'h03, 32'd3, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ERR_NONE},
      '{1'b0, 16'h0, 8'h0, 32'h0,
        16'h0000, 8'h01, 8'h02, 32'd1, 64'h0123_4567_89AB_CDEF, 1'b0, ERR_NONE},
      '{1'b1, 16'hFFFF, 8'hFF, 32'd0,
        16'hFFFF, 8'hFF, 8'h01, 32'd0, 64'hFEDC_BA98_7654_3210, 1'b0, ERR_NONE},
      '{1'b0, 16'h0, 8'h0, 32'h0,
        16'hFFFF, 8'hFF, 8'h02, 32'd1, 64'h0, 1'b1, ERR_LENGTH},
      '{1'b1, 16'hA55A, 8'h00, 32'hFFFF_FFFF,
        16'hA55A, 8'h00, 8'h03, 32'd2, 64'h8000_0000_0000_0001, 1'b0, ERR_NONE},
      '{1'b0, 16'h0, 8'h0, 32'h0,
        16'hA55A, 8'h00, 8'hFF, 32'd0, 64'h0, 1'b1, ERR_TYPE}
   };

   length_prefixed_frame_parser_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_byte_in     (req_byte_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_record_kind (rsp_record_kind),
      .rsp_frame_type  (rsp_frame_type),
      .rsp_frame_id    (rsp_frame_id),
      .rsp_body_length (rsp_body_length),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_error_code  (rsp_error_code),
      .rsp_last        (rsp_last),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit deframe_byte(input logic [BYTE_W-1:0] b,
                                       output frame_record_type rec);
      logic [ID_W-1:0] full_id;
      logic [LEN_W-1:0] hdr_len;
      logic [BYTE_W-1:0] hdr_type;
      err_type err;
      rec = '0;
      if (in_body) begin
         body_left = body_left - 1'b1;
         rec.kind = KIND_BODY;
         rec.data = b;
         rec.last = (body_left == '0);
         if (rec.last) begin
            in_body = 1'b0;
            hdr_count = '0;
         end
         return 1'b1;
      end
      if (hdr_count < HDR_WORD_END) begin
         hdr_word = {hdr_word[55:0], b};
         hdr_count++;
         return 1'b0;
      end
      if (hdr_count < HDR_LAST) begin
         id_word = {id_word[55:0], b};
         hdr_count++;
         return 1'b0;
      end
      full_id = {id_word[55:0], b};
      hdr_type = hdr_word[39:32];
      hdr_len = hdr_word[31:0];
      hdr_count = '0;
      if (hdr_word[63:48] != cfg_magic) err = ERR_MAGIC;
      else if (hdr_word[47:40] != cfg_version) err = ERR_VERSION;
      else if (hdr_len > cfg_max_len) err = ERR_LENGTH;
      else if (hdr_type < FTYPE_MIN || hdr_type > FTYPE_MAX) err = ERR_TYPE;
      else err = ERR_NONE;
      if (err != ERR_NONE) begin
         rec.kind = KIND_ERROR;
         rec.err = err;
         return 1'b1;
      end
      if (hdr_len != '0) begin
         in_body = 1'b1;
         body_left = hdr_len;
      end
      rec.kind = KIND_HEADER;
      rec.ftype = hdr_type[FTYPE_W-1:0];
      rec.id = full_id;
      rec.len = hdr_len;
      rec.last = (hdr_len == '0);
      return 1'b1;
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
                            input err_type typed_err = ERR_NONE);
      int unsigned gap;
      frame_record_type rec;
      gap = req_gaps ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clock);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_byte_in <= b;
      if (deframe_byte(b, rec)) begin
         if (typed) begin
            rec = '0;
            rec.kind = KIND_ERROR;
            rec.err = typed_err;
         end
         expected_records.push_back(rec);
      end
      bytes_offered++;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic send_frame(input logic [MAGIC_W-1:0] m, input logic [VER_W-1:0] v,
                             input logic [BYTE_W-1:0] t, input logic [LEN_W-1:0] len,
                             input logic [ID_W-1:0] id, input int unsigned cut,
                             input bit typed, input err_type typed_err, input bit pattern_body);
      logic [127:0] hdr;
      int unsigned k;
      hdr = {m, v, t, len, id};
      k = 0;
      for (int i = 0; i < cut; i++) begin
         send_byte(hdr[127 - 8*i -: 8], typed && i == HDR_BYTES - 1, typed_err);
      end
      if (cut == HDR_BYTES) begin
         while (in_body) begin
            send_byte(pattern_body ? {BYTE_W{k[0]}} : BYTE_W'($urandom));
            k++;
         end
      end
   endtask

   // completes a partial header or body in flight with random bytes
   task automatic finish_frame();
      while (hdr_count != '0 || in_body) send_byte(BYTE_W'($urandom));
   endtask

   task automatic send_random_frame(input bit noisy);
      int unsigned pick;
      int unsigned cap;
      int unsigned cut;
      logic [MAGIC_W-1:0] m;
      logic [VER_W-1:0] v;
      logic [BYTE_W-1:0] t;
      logic [LEN_W-1:0] len;
      longint unsigned span;
      err_type sel;
      finish_frame();
      pick = $urandom_range(0, 99);
      cap = (cfg_max_len < BODY_CAP) ? cfg_max_len : BODY_CAP;
      m = cfg_magic;
      v = cfg_version;
      t = BYTE_W'($urandom_range(FTYPE_MIN, FTYPE_MAX));
      len = $urandom_range(0, cap);
      if ($urandom_range(0, 2) == 0) len = 0;
      cut = HDR_BYTES;
      if (pick < 20) begin
         sel = err_type'($urandom_range(ERR_MAGIC, ERR_TYPE));
         if (sel == ERR_LENGTH && cfg_max_len == '1) sel = ERR_TYPE;
         case (sel)
            ERR_MAGIC: begin
               m = cfg_magic ^ MAGIC_W'($urandom_range(1, 65535));
               v = VER_W'($urandom);
               t = BYTE_W'($urandom);
               len = $urandom;
            end
            ERR_VERSION: begin
               v = cfg_version ^ VER_W'($urandom_range(1, 255));
               t = BYTE_W'($urandom);
               len = $urandom;
            end
            ERR_LENGTH: begin
               span = 64'h1_0000_0000 - cfg_max_len - 1;
               len = LEN_W'(cfg_max_len + 1 + ({$urandom, $urandom} % span));
               if (pick[0]) len = cfg_max_len + 1'b1;
               t = BYTE_W'($urandom);
            end
            default: begin
               t = BYTE_W'($urandom_range(0, 252));
               if (t != '0) t = t + FTYPE_MAX;
            end
         endcase
      end else if (noisy && pick < 30) begin
         cut = $urandom_range(1, HDR_BYTES - 1);
      end else if (noisy && pick < 40) begin
         repeat ($urandom_range(1, 12)) send_byte(BYTE_W'($urandom));
         return;
      end
      send_frame(m, v, t, len, {$urandom, $urandom}, cut, 1'b0, ERR_NONE, 1'b0);
   endtask

   // hold the input until every expected record is out, then let the block go quiet
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] wdata);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wdata;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_config(input logic [MAGIC_W-1:0] m, input logic [VER_W-1:0] v,
                               input logic [LEN_W-1:0] max_len);
      write_reg(CSR_MAGIC, {16'($urandom), m});
      write_reg(CSR_VERSION, {24'($urandom), v});
      write_reg(CSR_MAX_LEN, max_len);
      write_reg(CSR_SPARE, $urandom);
      cfg_magic = m;
      cfg_version = v;
      cfg_max_len = max_len;
   endtask

   task automatic check_field(input string name, input logic [ID_W-1:0] want,
                              input logic [ID_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : record_check
      frame_record_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_records.size() == 0) begin
            $display("%0t: unexpected record, expected none actual kind %0h", $time,
                     rsp_record_kind);
            mismatches++;
         end else begin
            want = expected_records.pop_front();
            check_field("record_kind", ID_W'(want.kind), ID_W'(rsp_record_kind));
            check_field("frame_type", ID_W'(want.ftype), ID_W'(rsp_frame_type));
            check_field("frame_id", want.id, rsp_frame_id);
            check_field("body_length", ID_W'(want.len), ID_W'(rsp_body_length));
            check_field("data_byte", ID_W'(want.data), ID_W'(rsp_data_byte));
            check_field("error_code", ID_W'(want.err), ID_W'(rsp_error_code));
            check_field("last", ID_W'(want.last), ID_W'(rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin : rsp_sink
      int unsigned pause;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            pause = LONG_HOLD;
         end else begin
            pause = rsp_gaps ? $urandom_range(0, MAX_GAP) : 0;
         end
         repeat (pause) begin
            rsp_ready <= 1'b0;
            @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin : stimulus
      logic [MAGIC_W-1:0] magic_pick;
      logic [VER_W-1:0] ver_pick;
      logic [LEN_W-1:0] max_pick;
      int unsigned phase_start;
      directed_row_type row;
      hdr_count = '0;
      hdr_word = '0;
      id_word = '0;
      in_body = 1'b0;
      body_left = '0;
      cfg_magic = MAGIC_RESET;
      cfg_version = VERSION_RESET;
      cfg_max_len = MAX_LEN_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      req_gaps = $urandom_range(0, 1) != 0;
      rsp_gaps = $urandom_range(0, 1) != 0;
      for (int r = 0; r < N_DIRECTED; r++) begin
         row = directed_rows[r];
         if (row.load_cfg) begin
            settle();
            write_config(row.cfg_magic, row.cfg_version, row.cfg_max_len);
         end
         send_frame(row.magic, row.version, row.ftype, row.len, row.id, HDR_BYTES,
                    row.typed, row.err, 1'b1);
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin
               magic_pick = '0;
               ver_pick = '0;
               max_pick = '0;
            end
            1: begin
               magic_pick = '1;
               ver_pick = '1;
               max_pick = '1;
            end
            default: begin
               magic_pick = MAGIC_W'($urandom);
               ver_pick = VER_W'($urandom);
               case ($urandom_range(0, 3))
                  0, 1: max_pick = $urandom_range(0, NOISY_MAX_LEN);
                  2: max_pick = $urandom;
                  default: max_pick = '1;
               endcase
            end
         endcase
         // a body in flight may run across the register writes
         if (!in_body || $urandom_range(0, 1) == 0) finish_frame();
         settle();
         write_config(magic_pick, ver_pick, max_pick);
         req_gaps = $urandom_range(0, 2) != 0;
         rsp_gaps = $urandom_range(0, 2) != 0;
         if (phase == STALL_PHASE) begin
            req_gaps = 1'b0;
            rsp_hold_request = 1'b1;
         end
         phase_start = bytes_offered;
         while (bytes_offered - phase_start < PHASE_BYTES) begin
            send_random_frame(cfg_max_len <= NOISY_MAX_LEN);
         end
      end

      finish_frame();
      settle();
      repeat (END_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_records.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
